// ----- sv/vrt_pkg.sv -----
// Shared types and codes for the voxel ray traversal unit.
// Used by the controller, the datapath and the top level; no dependencies.
package vrt_pkg;

  // item kinds on the input channel
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_REPLY = 1'b1;

  // result status codes
  localparam logic [2:0] ST_PROBE = 3'd0;
  localparam logic [2:0] ST_HIT   = 3'd1;
  localparam logic [2:0] ST_MISS  = 3'd2;
  localparam logic [2:0] ST_LIMIT = 3'd3;
  localparam logic [2:0] ST_IDLE  = 3'd4;

  localparam int NUM_AXES = 3;
  localparam int DIV_JOBS = 2 * NUM_AXES;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_STEP,
    S_EMIT
  } state_e;

  // what the pending result will report
  typedef enum logic [1:0] {
    K_IGNORED,
    K_HIT,
    K_MISS,
    K_CHECK
  } kind_e;

  typedef struct packed {
    logic       load_start;
    logic       div_start;
    logic       div_store;
    logic [2:0] div_sel;
    logic       step;
    logic       out_load;
    logic       zero_fields;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic reached;
  } sts_t;

endpackage

// ----- sv/vrt_div.sv -----
// Restoring divider, one quotient bit per cycle, result saturated to 32 bits.
// Depends on nothing; used by the datapath.
module vrt_div #(
  parameter int NW = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [15:0]   den_i,
  output logic          done_o,
  output logic [31:0]   quot_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic            run_q, run_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [16:0]     rem_q, rem_d;
  logic [NW-1:0]   num_q, num_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [16:0]     rem_sh;
  logic [63:0]     quo_wide;

  // shift one numerator bit in, subtract when it fits
  always_comb begin
    rem_sh = {rem_q[15:0], num_q[NW-1]};
    run_d  = run_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNTW'(NW);
      rem_d = '0;
      num_d = num_i;
      quo_d = '0;
    end else if (run_q && cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      num_d = num_q << 1;
      if (rem_sh >= {1'b0, den_i}) begin
        rem_d = rem_sh - {1'b0, den_i};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
    end else if (run_q) begin
      run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  // saturate the quotient
  assign quo_wide = 64'(quo_q);
  assign quot_o   = (quo_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo_wide[31:0];
  assign done_o   = run_q && (cnt_q == '0);

endmodule

// ----- sv/vrt_dpath.sv -----
// Datapath: ray setup, crossing tables, axis stepping and the output register.
// Depends on vrt_pkg and vrt_div.
module vrt_dpath import vrt_pkg::*; #(
  parameter int COORD_INT_BITS = 16,
  parameter int POS_FRAC_BITS  = 8,
  parameter int DIR_FRAC_BITS  = 14,
  parameter int T_FRAC_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [23:0] origin_x_i,
  input  logic [23:0] origin_y_i,
  input  logic [23:0] origin_z_i,
  input  logic [15:0] dir_x_i,
  input  logic [15:0] dir_y_i,
  input  logic [15:0] dir_z_i,
  input  logic [7:0]  max_distance_i,
  output logic [2:0]  status_o,
  output logic [15:0] voxel_x_o,
  output logic [15:0] voxel_y_o,
  output logic [15:0] voxel_z_o,
  output logic [23:0] travel_distance_o
);

  localparam int CW  = COORD_INT_BITS;
  localparam int DW  = POS_FRAC_BITS + 1;
  localparam int NW  = T_FRAC_BITS + DIR_FRAC_BITS + 1;
  localparam int SH  = T_FRAC_BITS + DIR_FRAC_BITS - POS_FRAC_BITS;
  localparam int SHR = (T_FRAC_BITS >= POS_FRAC_BITS) ? T_FRAC_BITS - POS_FRAC_BITS : 0;
  localparam int SHL = (T_FRAC_BITS >= POS_FRAC_BITS) ? 0 : POS_FRAC_BITS - T_FRAC_BITS;

  logic [CW-1:0] cell_q [NUM_AXES];
  logic          sign_q [NUM_AXES];
  logic [15:0]   mag_q  [NUM_AXES];
  logic [DW-1:0] dist_q [NUM_AXES];
  logic [31:0]   next_q [NUM_AXES];
  logic [31:0]   spc_q  [NUM_AXES];
  logic [31:0]   dnow_q;
  logic [7:0]    limit_q;

  logic [2:0]    status_q;
  logic [15:0]   vox_q [NUM_AXES];
  logic [23:0]   travel_q;

  logic [23:0]   org   [NUM_AXES];
  logic [15:0]   dir   [NUM_AXES];
  logic [23:0]   org_sh[NUM_AXES];
  logic          pos   [NUM_AXES];
  logic [CW-1:0] cell_in [NUM_AXES];
  logic [15:0]   mag_in  [NUM_AXES];
  logic [DW-1:0] dist_in [NUM_AXES];

  logic [1:0]    div_axis;
  logic          div_spc;
  logic [NW-1:0] div_num;
  logic          div_done;
  logic [31:0]   div_quot;
  logic [31:0]   div_res;

  logic [1:0]    step_axis;
  logic [32:0]   step_sum;
  logic [31:0]   step_next;
  logic [63:0]   travel_wide;

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  // per-axis setup: cell, step sign, direction magnitude, first boundary gap
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      org_sh[a]  = org[a] >> POS_FRAC_BITS;
      cell_in[a] = CW'(org_sh[a]);
      pos[a]     = !dir[a][15] && (dir[a] != '0);
      mag_in[a]  = dir[a][15] ? 16'(17'h10000 - {1'b0, dir[a]}) : dir[a];
      if (pos[a]) begin
        dist_in[a] = (DW'(1) << POS_FRAC_BITS) - DW'(org[a][POS_FRAC_BITS-1:0]);
      end else begin
        dist_in[a] = DW'(org[a][POS_FRAC_BITS-1:0]);
      end
    end
  end

  // select the division job: first three are gaps, last three spacings
  always_comb begin
    div_spc  = (cmd_i.div_sel >= 3'(NUM_AXES));
    div_axis = div_spc ? 2'(cmd_i.div_sel - 3'(NUM_AXES)) : cmd_i.div_sel[1:0];
    if (div_spc) begin
      div_num = NW'(1) << (T_FRAC_BITS + DIR_FRAC_BITS);
    end else begin
      div_num = NW'(dist_q[div_axis]) << SH;
    end
  end

  vrt_div #(
    .NW (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (mag_q[div_axis]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // a zero direction component never crosses: saturate both table entries
  assign div_res = (mag_q[div_axis] == 16'd0) ? 32'hFFFF_FFFF : div_quot;

  // pick the axis with the smallest crossing, ties toward z then y
  always_comb begin
    if (next_q[0] < next_q[1]) begin
      step_axis = (next_q[0] < next_q[2]) ? 2'd0 : 2'd2;
    end else begin
      step_axis = (next_q[1] < next_q[2]) ? 2'd1 : 2'd2;
    end
    step_sum  = {1'b0, next_q[step_axis]} + {1'b0, spc_q[step_axis]};
    step_next = step_sum[32] ? 32'hFFFF_FFFF : step_sum[31:0];
  end

  // ray state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cell_q[a] <= cell_in[a];
        sign_q[a] <= pos[a];
        mag_q[a]  <= mag_in[a];
        dist_q[a] <= dist_in[a];
      end
      dnow_q  <= '0;
      limit_q <= max_distance_i;
    end else if (cmd_i.step) begin
      if (sign_q[step_axis]) begin
        cell_q[step_axis] <= cell_q[step_axis] + 1'b1;
      end else begin
        cell_q[step_axis] <= cell_q[step_axis] - 1'b1;
      end
      dnow_q            <= next_q[step_axis];
      next_q[step_axis] <= step_next;
    end
    if (cmd_i.div_store) begin
      if (div_spc) begin
        spc_q[div_axis]  <= div_res;
      end else begin
        next_q[div_axis] <= div_res;
      end
    end
  end

  // distance in position units, saturated to the field
  assign travel_wide = (64'(dnow_q) >> SHR) << SHL;

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.status;
      for (int a = 0; a < NUM_AXES; a++) begin
        vox_q[a] <= cmd_i.zero_fields ? 16'd0 : 16'(cell_q[a]);
      end
      if (cmd_i.zero_fields) begin
        travel_q <= '0;
      end else begin
        travel_q <= (travel_wide > 64'hFF_FFFF) ? 24'hFF_FFFF : travel_wide[23:0];
      end
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.reached  = 64'(dnow_q) >= (64'(limit_q) << T_FRAC_BITS);

  assign status_o          = status_q;
  assign voxel_x_o         = vox_q[0];
  assign voxel_y_o         = vox_q[1];
  assign voxel_z_o         = vox_q[2];
  assign travel_distance_o = travel_q;

endmodule

// ----- sv/vrt_ctrl.sv -----
// Controller: accepts items, sequences the six divisions and a step,
// and loads the output register. Depends on vrt_pkg.
module vrt_ctrl import vrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic mode_i,
  input  logic voxel_present_i,
  input  logic voxel_solid_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e     state_q, state_d;
  kind_e      kind_q, kind_d;
  logic [2:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;
  logic       last_job;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_job = (idx_q == 3'(DIV_JOBS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_START) begin
            state_d = S_DIV_GO;
          end else if (busy_q && voxel_present_i && !voxel_solid_i) begin
            state_d = S_STEP;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = last_job ? S_EMIT : S_DIV_GO;
        end
      end
      S_STEP:     state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // result kind, job index, ray-active flag, output valid
  always_comb begin
    kind_d      = kind_q;
    idx_d       = idx_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      idx_d = '0;
      if (mode_i == MODE_START) begin
        kind_d = K_CHECK;
      end else if (!busy_q) begin
        kind_d = K_IGNORED;
      end else if (!voxel_present_i) begin
        kind_d = K_MISS;
      end else if (voxel_solid_i) begin
        kind_d = K_HIT;
      end else begin
        kind_d = K_CHECK;
      end
    end
    if (state_q == S_DIV_WAIT && sts_i.div_done) begin
      idx_d = idx_q + 1'b1;
    end
    if (state_q == S_EMIT && out_free) begin
      out_valid_d = 1'b1;
      busy_d      = (kind_q == K_CHECK) && !sts_i.reached;
    end
  end

  // datapath commands
  always_comb begin
    cmd_o             = '0;
    cmd_o.load_start  = accept && (mode_i == MODE_START);
    cmd_o.div_sel     = idx_q;
    cmd_o.div_start   = (state_q == S_DIV_GO);
    cmd_o.div_store   = (state_q == S_DIV_WAIT) && sts_i.div_done;
    cmd_o.step        = (state_q == S_STEP);
    cmd_o.out_load    = (state_q == S_EMIT) && out_free;
    cmd_o.zero_fields = (kind_q == K_IGNORED);
    case (kind_q)
      K_IGNORED: cmd_o.status = ST_IDLE;
      K_HIT:     cmd_o.status = ST_HIT;
      K_MISS:    cmd_o.status = ST_MISS;
      K_CHECK:   cmd_o.status = sts_i.reached ? ST_LIMIT : ST_PROBE;
      default:   cmd_o.status = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_IGNORED;
      idx_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      idx_q       <= idx_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register loaded while a result is still held");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV_WAIT))
    else $error("divider finished outside the wait state");

  a_busy_falls_at_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(state_q == S_EMIT))
    else $error("ray ended without emitting a result");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

// ----- sv/voxel_ray_traversal_unit.sv -----
// Start item: set by six divisions run one bit per cycle through a single shared
// divider, after which the result is emitted. Probe reply: the result is loaded
// into the output register in S_EMIT, reached through S_STEP when a step is taken;
// S_EMIT holds while a held result is stalled. One item in flight; the next item is
// taken while a result still waits. rst_ni clears all control state at once.
module voxel_ray_traversal_unit import vrt_pkg::*; #(
  parameter int COORD_INT_BITS = 16,
  parameter int POS_FRAC_BITS  = 8,
  parameter int DIR_FRAC_BITS  = 14,
  parameter int T_FRAC_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [23:0] origin_x_i,
  input  logic [23:0] origin_y_i,
  input  logic [23:0] origin_z_i,
  input  logic [15:0] dir_x_i,
  input  logic [15:0] dir_y_i,
  input  logic [15:0] dir_z_i,
  input  logic [7:0]  max_distance_i,
  input  logic        voxel_present_i,
  input  logic        voxel_solid_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] voxel_x_o,
  output logic [15:0] voxel_y_o,
  output logic [15:0] voxel_z_o,
  output logic [23:0] travel_distance_o
);

  cmd_t cmd;
  sts_t sts;

  vrt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .voxel_present_i (voxel_present_i),
    .voxel_solid_i   (voxel_solid_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  vrt_dpath #(
    .COORD_INT_BITS (COORD_INT_BITS),
    .POS_FRAC_BITS  (POS_FRAC_BITS),
    .DIR_FRAC_BITS  (DIR_FRAC_BITS),
    .T_FRAC_BITS    (T_FRAC_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .origin_x_i        (origin_x_i),
    .origin_y_i        (origin_y_i),
    .origin_z_i        (origin_z_i),
    .dir_x_i           (dir_x_i),
    .dir_y_i           (dir_y_i),
    .dir_z_i           (dir_z_i),
    .max_distance_i    (max_distance_i),
    .status_o          (status_o),
    .voxel_x_o         (voxel_x_o),
    .voxel_y_o         (voxel_y_o),
    .voxel_z_o         (voxel_z_o),
    .travel_distance_o (travel_distance_o)
  );

endmodule

// ----- sim/tb_voxel_ray_traversal_unit.sv -----
// Self-checking testbench for voxel_ray_traversal_unit: predicts every result of the stepper.
// Depends on vrt_pkg and the unit's RTL; drives both valid/stall channels with random idling.
module tb_voxel_ray_traversal_unit;
  import vrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_ITEMS = 500;
  localparam logic [31:0] T_SAT = 32'hFFFF_FFFF;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
    logic [23:0] travel;
  } ray_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        mode_i;
  logic [23:0] origin_x_i, origin_y_i, origin_z_i;
  logic [15:0] dir_x_i, dir_y_i, dir_z_i;
  logic [7:0]  max_distance_i;
  logic        voxel_present_i;
  logic        voxel_solid_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [15:0] voxel_x_o, voxel_y_o, voxel_z_o;
  logic [23:0] travel_distance_o;

  voxel_ray_traversal_unit u_dut (.*);

  // predicted traversal state
  logic        ray_active;
  logic [15:0] cell_pos [3];
  logic        steps_up [3];
  logic [31:0] next_cross [3];
  logic [31:0] cross_spacing [3];
  logic [31:0] dist_now;
  logic [7:0]  dist_limit;

  ray_result_t expected_results [$];
  int          error_count;
  int          items_sent;
  int          rays_started;
  int          results_checked;
  int          hits_seen;
  int          limits_seen;
  int          tx_idle_pct;
  int          rx_stall_pct;

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // load one axis of a new ray
  task automatic load_axis(input int a, input logic [23:0] origin, input logic [15:0] dir);
    logic [8:0]  frac_dist;
    logic [16:0] mag;
    logic        up;
    logic [63:0] q;
    up = !dir[15] && (dir != 16'd0);
    mag = dir[15] ? (17'h10000 - {1'b0, dir}) : {1'b0, dir};
    cell_pos[a] = origin[23:8];
    steps_up[a] = up;
    if (mag == 17'd0) begin
      next_cross[a] = T_SAT;
      cross_spacing[a] = T_SAT;
    end else begin
      frac_dist = up ? (9'd256 - origin[7:0]) : {1'b0, origin[7:0]};
      q = ({55'd0, frac_dist} << 22) / mag;
      next_cross[a] = (q > T_SAT) ? T_SAT : q[31:0];
      q = (64'd1 << 30) / mag;
      cross_spacing[a] = (q > T_SAT) ? T_SAT : q[31:0];
    end
  endtask

  function automatic ray_result_t make_result(input logic [2:0] st);
    ray_result_t r;
    r.status = st;
    r.vx = cell_pos[0];
    r.vy = cell_pos[1];
    r.vz = cell_pos[2];
    r.travel = dist_now[31:8];
    return r;
  endfunction

  // advance the predicted traversal by one accepted item
  task automatic predict_traversal(output ray_result_t r);
    int          a;
    logic [32:0] sum;
    if (mode_i == MODE_START) begin
      load_axis(0, origin_x_i, dir_x_i);
      load_axis(1, origin_y_i, dir_y_i);
      load_axis(2, origin_z_i, dir_z_i);
      dist_now = 32'd0;
      dist_limit = max_distance_i;
      rays_started++;
      ray_active = (dist_limit != 8'd0);
      r = make_result(ray_active ? ST_PROBE : ST_LIMIT);
    end else if (!ray_active) begin
      r = '{ST_IDLE, 16'd0, 16'd0, 16'd0, 24'd0};
    end else if (!voxel_present_i) begin
      ray_active = 1'b0;
      r = make_result(ST_MISS);
    end else if (voxel_solid_i) begin
      ray_active = 1'b0;
      r = make_result(ST_HIT);
    end else begin
      // pick the axis crossed first, ties toward z then y
      if (next_cross[0] < next_cross[1]) a = (next_cross[0] < next_cross[2]) ? 0 : 2;
      else a = (next_cross[1] < next_cross[2]) ? 1 : 2;
      cell_pos[a] = steps_up[a] ? cell_pos[a] + 16'd1 : cell_pos[a] - 16'd1;
      dist_now = next_cross[a];
      sum = {1'b0, next_cross[a]} + {1'b0, cross_spacing[a]};
      next_cross[a] = sum[32] ? T_SAT : sum[31:0];
      if ({32'd0, dist_now} >= ({56'd0, dist_limit} << 16)) begin
        ray_active = 1'b0;
        r = make_result(ST_LIMIT);
      end else begin
        r = make_result(ST_PROBE);
      end
    end
  endtask

  // drive one item, hold it until accepted, then record its prediction
  task automatic send_item(input logic mode, input logic [23:0] ox, oy, oz,
                           input logic [15:0] dx, dy, dz, input logic [7:0] md,
                           input logic present, solid);
    ray_result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= mode;
    origin_x_i <= ox;
    origin_y_i <= oy;
    origin_z_i <= oz;
    dir_x_i <= dx;
    dir_y_i <= dy;
    dir_z_i <= dz;
    max_distance_i <= md;
    voxel_present_i <= present;
    voxel_solid_i <= solid;
    do @(posedge clk_i); while (in_stall_o);
    predict_traversal(r);
    expected_results.push_back(r);
    items_sent++;
  endtask

  task automatic send_start(input logic [23:0] ox, oy, oz, input logic [15:0] dx, dy, dz,
                            input logic [7:0] md);
    send_item(MODE_START, ox, oy, oz, dx, dy, dz, md,
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic send_reply(input logic present, solid);
    send_item(MODE_REPLY, 24'($urandom), 24'($urandom), 24'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), present, solid);
  endtask

  function automatic logic [15:0] random_dir();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($urandom_range(32768) - 16384);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, exp_val);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, exp_val);
    error_count++;
  endtask

  // check every accepted result against the oldest prediction
  always @(posedge clk_i) begin
    ray_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", 32'(status_o), 32'd0);
      end else begin
        e = expected_results.pop_front();
        results_checked++;
        if (status_o == ST_HIT) hits_seen++;
        if (status_o == ST_LIMIT) limits_seen++;
        if (status_o !== e.status)
          report_mismatch("status", 32'(status_o), 32'(e.status));
        if (voxel_x_o !== e.vx) report_mismatch("voxel_x", 32'(voxel_x_o), 32'(e.vx));
        if (voxel_y_o !== e.vy) report_mismatch("voxel_y", 32'(voxel_y_o), 32'(e.vy));
        if (voxel_z_o !== e.vz) report_mismatch("voxel_z", 32'(voxel_z_o), 32'(e.vz));
        if (travel_distance_o !== e.travel)
          report_mismatch("travel_distance", 32'(travel_distance_o), 32'(e.travel));
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // extremes, boundaries and the special cases of the stepper
  task automatic test_directed();
    send_reply(1'b1, 1'b0);                        // reply while idle
    send_start(24'h000100, 24'h000280, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 8'd0);
    send_reply(1'b1, 1'b1);                        // idle again after zero limit
    // all-zero direction: tie picks z, saturates, cell wraps below zero
    send_start(24'h000000, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 8'd255);
    send_reply(1'b1, 1'b0);
    // negative directions on a boundary cross at distance zero
    send_start(24'h000500, 24'h000300, 24'h000700, -16'sd16384, -16'sd9459, -16'sd9459, 8'd3);
    repeat (4) send_reply(1'b1, 1'b0);
    // top corner, positive extremes, ray wraps and meets absent voxel
    send_start(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'sd16384, 16'sd16384, 16'sd16384, 8'd255);
    send_reply(1'b1, 1'b0);
    send_reply(1'b0, 1'b0);
    // hit, then later a start while busy
    send_start(24'h123456, 24'h00FF80, 24'h0A0A0A, 16'sd9459, -16'sd9459, 16'sd9459, 8'd20);
    send_reply(1'b1, 1'b0);
    send_reply(1'b1, 1'b1);
    send_start(24'h0000FF, 24'h800001, 24'h7FFF7F, 16'sd1, -16'sd1, 16'sd16383, 8'd2);
    send_reply(1'b1, 1'b0);
    send_start(24'h001080, 24'h002040, 24'h0030C0, 16'sd11585, 16'sd11585, 16'sd0, 8'd1);
    send_reply(1'b1, 1'b0);
    send_reply(1'b1, 1'b0);
  endtask

  // random rays: mostly clean probe sequences, some absent or solid voxels and noise
  task automatic test_random_rays(input int n_items);
    int stop_at;
    int guard;
    int pick;
    logic [7:0] lim;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0)
        send_reply(1'($urandom_range(1)), 1'($urandom_range(1)));
      lim = ($urandom_range(15) == 0) ? 8'($urandom) : 8'($urandom_range(6));
      send_start(24'($urandom), 24'($urandom), 24'($urandom),
                 random_dir(), random_dir(), random_dir(), lim);
      guard = 0;
      while (ray_active && guard < 30) begin
        pick = $urandom_range(99);
        if (pick < 3) break;                       // abandon: next start arrives while busy
        send_reply(pick >= 6, pick >= 6 && pick < 10);
        guard++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_START;
    origin_x_i = '0;
    origin_y_i = '0;
    origin_z_i = '0;
    dir_x_i = '0;
    dir_y_i = '0;
    dir_z_i = '0;
    max_distance_i = '0;
    voxel_present_i = 1'b0;
    voxel_solid_i = 1'b0;
    out_stall_i = 1'b0;
    ray_active = 1'b0;
    for (int a = 0; a < 3; a++) begin
      cell_pos[a] = '0;
      steps_up[a] = 1'b0;
      next_cross[a] = '0;
      cross_spacing[a] = '0;
    end
    dist_now = '0;
    dist_limit = '0;
    error_count = 0;
    items_sent = 0;
    rays_started = 0;
    results_checked = 0;
    hits_seen = 0;
    limits_seen = 0;
    tx_idle_pct = 37;
    rx_stall_pct = 62;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_rays(TARGET_ITEMS / 3);
    tx_idle_pct = 62;
    rx_stall_pct = 37;
    test_random_rays(TARGET_ITEMS / 3);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    test_random_rays(TARGET_ITEMS / 3);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d items in %0d rays; %0d results checked (%0d hits, %0d limit stops).",
             items_sent, rays_started, results_checked, hits_seen, limits_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("voxel_ray_traversal_unit test passed");
    end else begin
      $display("voxel_ray_traversal_unit test failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #30ms;
    $display("voxel_ray_traversal_unit test failed");
    $finish;
  end

endmodule
